// ===== rtl/ekmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ekmf_pkg;

   localparam int VAL_W = 17;
   localparam int SUM_W = 20;

   localparam logic [VAL_W-1:0] RES_MAX = 17'h1FFFF;
   localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ALU_MIN     = 2'd0,
      ALU_SUB_SAT = 2'd1,
      ALU_ADD_SAT = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
   } alu_req_type;

endpackage

`default_nettype wire

// ===== rtl/edmonds_karp_max_flow_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Edmonds-Karp max flow engine over a dense residual matrix.
// Request channel (req_*): command 0 writes one capacity entry, 1 runs max
// flow from source_node to sink_node, 2 reads one residual entry back.
// Response channel (rsp_*): one response for run and read, none for write.
// Handshake: a transfer happens on a clock edge with valid high, stall low.
// Writes are taken back to back; a read passes through the READ and FINISH
// states, and the engine returns to idle as its response goes valid.
// A run is serial: each breadth-first search scans all neighbors of a
// dequeued node (SCAN_ADDR, SCAN_EVAL), and augment walks the path back
// per edge (AUG_PRED, AUG_FWD, AUG_REV), repeated until sink is unreachable;
// one residual read port serializes it. req_stall is high while busy.
// Reset: a pass clears all 2^(2*clog2(NODES)) residual memory entries,
// one entry a cycle, with requests stalled.
// A finished response waits in a holding register while a stalled response
// sits in the output register; the engine does not take a new request until it moves there.
// Source equal to sink returns error_code 1 with zero flow.

module edmonds_karp_max_flow_unit #(
   parameter int NODES     = 16,
   parameter int CAP_WIDTH = 16,
   parameter int INF_FLOW  = 131071
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_command,
   input  wire  [3:0]  req_row_node,
   input  wire  [3:0]  req_col_node,
   input  wire  [15:0] req_cap_value,
   input  wire  [3:0]  req_source_node,
   input  wire  [3:0]  req_sink_node,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [19:0] rsp_total_flow,
   output logic [16:0] rsp_residual_value,
   output logic        rsp_error_code
);
   import ekmf_pkg::*;

   localparam int NW    = $clog2(NODES);
   localparam int CW    = $clog2(NODES + 1);
   localparam int AW    = 2 * NW;
   localparam int DEPTH = 1 << AW;
   localparam logic [15:0] CAP_MASK =
      (CAP_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << CAP_WIDTH) - 32'd1);
   localparam logic [VAL_W-1:0] INF_VAL  = VAL_W'(INF_FLOW);
   localparam logic [NW-1:0]    LAST_IDX = NW'(NODES - 1);
   localparam logic [CW-1:0]    NODE_CNT = CW'(NODES);

   typedef enum logic [13:0] {
      ST_CLEAR     = 14'b00000000000001,
      ST_IDLE      = 14'b00000000000010,
      ST_READ      = 14'b00000000000100,
      ST_SRCH_INIT = 14'b00000000001000,
      ST_POP       = 14'b00000000010000,
      ST_POP_WAIT  = 14'b00000000100000,
      ST_SCAN_ADDR = 14'b00000001000000,
      ST_SCAN_EVAL = 14'b00000010000000,
      ST_AUG_INIT  = 14'b00000100000000,
      ST_AUG_PRED  = 14'b00001000000000,
      ST_AUG_FWD   = 14'b00010000000000,
      ST_AUG_REV   = 14'b00100000000000,
      ST_FINISH    = 14'b01000000000000,
      ST_SPARE     = 14'b10000000000000
   } state_type;

   // storage
   logic [VAL_W-1:0] res_mem  [DEPTH];
   logic [NW-1:0]    pred_mem [NODES];
   logic [VAL_W-1:0] bn_mem   [NODES];
   logic [NW-1:0]    q_mem    [NODES];

   // control
   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [NODES-1:0] seen_ff, seen_in;
   logic [CW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0]    idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [NW-1:0]    src_ff, src_in, dst_ff, dst_in;
   logic [NW-1:0]    cur_ff, cur_in, k_ff, k_in, prev_ff, prev_in;
   logic [VAL_W-1:0] inc_ff, inc_in;
   logic [SUM_W-1:0] flow_sum_ff, flow_sum_in;
   logic             rd_ok_ff, rd_ok_in;
   logic [SUM_W-1:0] pend_flow_ff, pend_flow_in;
   logic [VAL_W-1:0] pend_val_ff, pend_val_in;
   logic             pend_err_ff, pend_err_in;
   logic [SUM_W-1:0] rsp_flow_ff, rsp_flow_in;
   logic [VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic             rsp_err_ff, rsp_err_in;

   // memory read data (registered)
   logic [VAL_W-1:0] res_rd_ff;
   logic [NW-1:0]    pred_rd_ff;
   logic [VAL_W-1:0] bn_rd_ff;
   logic [NW-1:0]    q_rd_ff;

   // memory ports
   logic [AW-1:0]    res_raddr, res_waddr;
   logic             res_we;
   logic [VAL_W-1:0] res_wdata;
   logic [NW-1:0]    pred_raddr, bn_raddr;
   logic             scan_take;
   logic             q_we;
   logic [NW-1:0]    q_waddr, q_wdata;
   logic             bn_we;
   logic [NW-1:0]    bn_waddr;
   logic [VAL_W-1:0] bn_wdata;

   alu_req_type      alu_req;
   logic [VAL_W-1:0] alu_result;

   logic             accept;
   logic             rsp_free;
   logic [NW-1:0]    row_idx, col_idx, req_src, req_dst;
   logic             rc_ok, run_ok;
   logic [SUM_W:0]   flow_add;

   ekmf_alu u_alu (
      .alu_req    (alu_req),
      .alu_result (alu_result)
   );

   assign row_idx = NW'(req_row_node);
   assign col_idx = NW'(req_col_node);
   assign req_src = NW'(req_source_node);
   assign req_dst = NW'(req_sink_node);
   assign rc_ok   = (32'(req_row_node) < NODES) && (32'(req_col_node) < NODES);
   assign run_ok  = (32'(req_source_node) < NODES) && (32'(req_sink_node) < NODES);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // neighbor taken into the search queue
   assign scan_take = (idx_ff != src_ff) && (res_rd_ff != '0) && !seen_ff[idx_ff]
                      && (tail_ff < NODE_CNT);

   assign flow_add = {1'b0, flow_sum_ff} + {{(SUM_W + 1 - VAL_W){1'b0}}, bn_rd_ff};

   // shared compare/saturate unit
   always_comb begin
      alu_req.a  = res_rd_ff;
      alu_req.b  = inc_ff;
      alu_req.op = ALU_MIN;
      if (state_ff == ST_SCAN_EVAL) begin
         alu_req.b = bn_rd_ff;
      end else if (state_ff == ST_AUG_FWD) begin
         alu_req.op = ALU_SUB_SAT;
      end else if (state_ff == ST_AUG_REV) begin
         alu_req.op = ALU_ADD_SAT;
      end
   end

   // residual memory port control
   always_comb begin
      res_raddr = {row_idx, col_idx};
      res_we    = 1'b0;
      res_waddr = {row_idx, col_idx};
      res_wdata = {1'b0, req_cap_value & CAP_MASK};
      unique case (state_ff)
         ST_CLEAR: begin
            res_we    = 1'b1;
            res_waddr = clr_ff;
            res_wdata = '0;
         end
         ST_IDLE: begin
            res_we = accept && (cmd_type'(req_command) == CMD_WRITE) && rc_ok;
         end
         ST_SCAN_ADDR: res_raddr = {cur_ff, idx_ff};
         ST_AUG_PRED:  res_raddr = {pred_rd_ff, k_ff};
         ST_AUG_FWD: begin
            res_raddr = {k_ff, prev_ff};
            res_we    = 1'b1;
            res_waddr = {prev_ff, k_ff};
            res_wdata = alu_result;
         end
         ST_AUG_REV: begin
            res_we    = 1'b1;
            res_waddr = {k_ff, prev_ff};
            res_wdata = alu_result;
         end
         default: ;
      endcase
   end

   // search scratch port control
   always_comb begin
      pred_raddr = (state_ff == ST_AUG_INIT) ? dst_ff : prev_ff;
      bn_raddr   = (state_ff == ST_POP_WAIT) ? q_rd_ff : cur_ff;
      q_we       = 1'b0;
      q_waddr    = tail_ff[NW-1:0];
      q_wdata    = idx_ff;
      bn_we      = 1'b0;
      bn_waddr   = idx_ff;
      bn_wdata   = alu_result;
      if (state_ff == ST_SRCH_INIT) begin
         q_we     = 1'b1;
         q_waddr  = '0;
         q_wdata  = src_ff;
         bn_we    = 1'b1;
         bn_waddr = src_ff;
         bn_wdata = INF_VAL;
      end else if (state_ff == ST_SCAN_EVAL) begin
         q_we  = scan_take;
         bn_we = scan_take;
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= res_wdata;
      end
      res_rd_ff <= res_mem[res_raddr];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN_EVAL) && scan_take) begin
         pred_mem[idx_ff] <= cur_ff;
      end
      pred_rd_ff <= pred_mem[pred_raddr];
   end

   always_ff @(posedge clock) begin
      if (bn_we) begin
         bn_mem[bn_waddr] <= bn_wdata;
      end
      bn_rd_ff <= bn_mem[bn_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_waddr] <= q_wdata;
      end
      q_rd_ff <= q_mem[head_ff[NW-1:0]];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      seen_in      = seen_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      idx_in       = idx_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      prev_in      = prev_ff;
      inc_in       = inc_ff;
      flow_sum_in  = flow_sum_ff;
      rd_ok_in     = rd_ok_ff;
      pend_flow_in = pend_flow_ff;
      pend_val_in  = pend_val_ff;
      pend_err_in  = pend_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_flow_in  = rsp_flow_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               pend_flow_in = '0;
               pend_val_in  = '0;
               pend_err_in  = 1'b0;
               src_in       = req_src;
               dst_in       = req_dst;
               rd_ok_in     = rc_ok;
               priority case (cmd_type'(req_command))
                  CMD_READ: state_in = ST_READ;
                  CMD_RUN: begin
                     flow_sum_in = '0;
                     if (req_source_node == req_sink_node) begin
                        pend_err_in = 1'b1;
                        state_in    = ST_FINISH;
                     end else if (!run_ok) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_SRCH_INIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            pend_val_in = rd_ok_ff ? res_rd_ff : '0;
            state_in    = ST_FINISH;
         end
         ST_SRCH_INIT: begin
            seen_in  = {{(NODES - 1){1'b0}}, 1'b1} << src_ff;
            head_in  = '0;
            tail_in  = CW'(1);
            state_in = ST_POP;
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               pend_flow_in = flow_sum_ff;
               state_in     = ST_FINISH;
            end else begin
               head_in  = head_ff + 1'b1;
               state_in = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            cur_in = q_rd_ff;
            idx_in = '0;
            state_in = (q_rd_ff == dst_ff) ? ST_AUG_INIT : ST_SCAN_ADDR;
         end
         ST_SCAN_ADDR: state_in = ST_SCAN_EVAL;
         ST_SCAN_EVAL: begin
            if (scan_take) begin
               seen_in[idx_ff] = 1'b1;
               tail_in         = tail_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff == LAST_IDX) ? ST_POP : ST_SCAN_ADDR;
         end
         ST_AUG_INIT: begin
            inc_in      = bn_rd_ff;
            flow_sum_in = flow_add[SUM_W] ? SUM_MAX : flow_add[SUM_W-1:0];
            k_in        = dst_ff;
            state_in    = ST_AUG_PRED;
         end
         ST_AUG_PRED: begin
            prev_in  = pred_rd_ff;
            state_in = ST_AUG_FWD;
         end
         ST_AUG_FWD: state_in = ST_AUG_REV;
         ST_AUG_REV: begin
            k_in     = prev_ff;
            state_in = (prev_ff == src_ff) ? ST_SRCH_INIT : ST_AUG_PRED;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_flow_in  = pend_flow_ff;
               rsp_val_in   = pend_val_ff;
               rsp_err_in   = pend_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         seen_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         idx_ff       <= '0;
         flow_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         idx_ff       <= idx_in;
         flow_sum_ff  <= flow_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      cur_ff       <= cur_in;
      k_ff         <= k_in;
      prev_ff      <= prev_in;
      inc_ff       <= inc_in;
      rd_ok_ff     <= rd_ok_in;
      pend_flow_ff <= pend_flow_in;
      pend_val_ff  <= pend_val_in;
      pend_err_ff  <= pend_err_in;
      rsp_flow_ff  <= rsp_flow_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_total_flow     = rsp_flow_ff;
   assign rsp_residual_value = rsp_val_ff;
   assign rsp_error_code     = rsp_err_ff;

endmodule

`default_nettype wire

// ===== rtl/ekmf_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ekmf_alu (
   input  wire  ekmf_pkg::alu_req_type      alu_req,
   output logic [ekmf_pkg::VAL_W-1:0]       alu_result
);
   import ekmf_pkg::*;

   logic [VAL_W:0] sum;
   logic [VAL_W:0] diff;

   assign sum  = {1'b0, alu_req.a} + {1'b0, alu_req.b};
   assign diff = {1'b0, alu_req.a} - {1'b0, alu_req.b};

   always_comb begin
      unique case (alu_req.op)
         ALU_MIN:     alu_result = diff[VAL_W] ? alu_req.a : alu_req.b;
         ALU_SUB_SAT: alu_result = diff[VAL_W] ? '0 : diff[VAL_W-1:0];
         ALU_ADD_SAT: alu_result = sum[VAL_W] ? RES_MAX : sum[VAL_W-1:0];
         default:     alu_result = '0;
      endcase
   end

endmodule

`default_nettype wire
